// ===== rtl/wst_pkg.sv =====
`default_nettype none
package wst_pkg;

	localparam int CW    = 32;
	localparam int F     = 16;
	localparam int QB    = CW - 1;
	localparam int PRODW = 2 * CW;
	localparam int CLIPW = 50;
	localparam int MAGW  = CLIPW;
	localparam int SCRW  = 15;
	localparam int CFGW  = 64;
	localparam int IDXW  = 3;
	localparam int MULW  = CW + 1 + SCRW + 1;

	localparam logic [CFGW-1:0] RST_ROW_X  = 64'h0000_0001_0000_0000;
	localparam logic [CFGW-1:0] RST_ROW_Y  = 64'h0000_0000_0001_0000;
	localparam logic [CFGW-1:0] RST_ROW_W  = 64'h0;
	localparam logic [CFGW-1:0] RST_OFF_XY = 64'h0;
	localparam logic [CW-1:0]   RST_OFF_W  = 32'h0001_0000;
	localparam logic [SCRW-1:0] RST_SCR_W  = 15'd640;
	localparam logic [SCRW-1:0] RST_SCR_H  = 15'd480;

	typedef enum logic [IDXW-1:0] {
		REG_ROW_X  = 3'd0,
		REG_ROW_Y  = 3'd1,
		REG_ROW_W  = 3'd2,
		REG_OFF_XY = 3'd3,
		REG_OFF_W  = 3'd4,
		REG_SCR_W  = 3'd5,
		REG_SCR_H  = 3'd6
	} wst_reg_t;

	typedef struct packed {
		logic signed [CW-1:0] world_x;
		logic signed [CW-1:0] world_y;
	} wst_in_t;

	typedef struct packed {
		logic signed [CW-1:0] pix_x;
		logic signed [CW-1:0] pix_y;
		logic                 bad_point;
	} wst_out_t;

	typedef struct packed {
		logic [MAGW-1:0] ub;
		logic [MAGW-1:0] rx;
		logic [MAGW-1:0] ry;
		logic [QB-1:0]   lx;
		logic [QB-1:0]   ly;
		logic [QB-1:0]   qx;
		logic [QB-1:0]   qy;
		logic            neg_x;
		logic            neg_y;
		logic            ovf_x;
		logic            ovf_y;
		logic            zb;
		logic            zax;
		logic            zay;
	} wst_div_t;

endpackage
`default_nettype wire

// ===== rtl/wst_div_step.sv =====
`default_nettype none
module wst_div_step (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire wst_pkg::wst_div_t d,
	output wst_pkg::wst_div_t      q
);

	logic [wst_pkg::MAGW:0]   tx;
	logic [wst_pkg::MAGW:0]   ty;
	logic                     gx;
	logic                     gy;
	wst_pkg::wst_div_t        nxt;

	always_comb begin
		tx = {d.rx, d.lx[wst_pkg::QB-1]};
		ty = {d.ry, d.ly[wst_pkg::QB-1]};
		gx = tx >= {1'b0, d.ub};
		gy = ty >= {1'b0, d.ub};
		nxt = d;
		nxt.rx = gx ? wst_pkg::MAGW'(tx - {1'b0, d.ub}) : wst_pkg::MAGW'(tx);
		nxt.ry = gy ? wst_pkg::MAGW'(ty - {1'b0, d.ub}) : wst_pkg::MAGW'(ty);
		nxt.lx = {d.lx[wst_pkg::QB-2:0], 1'b0};
		nxt.ly = {d.ly[wst_pkg::QB-2:0], 1'b0};
		nxt.qx = {d.qx[wst_pkg::QB-2:0], gx};
		nxt.qy = {d.qy[wst_pkg::QB-2:0], gy};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/world_to_screen_transform_top.sv =====
// World point to window pixel transform.
// Input channel in_valid/in_ready/in_pt carries one Q16.16 world point per
// transfer; output channel out_valid/out_ready/out_pt returns screen x, y
// (Q16.16 pixels, origin top-left, y down) and a bad_point flag for a zero
// clip w or any saturation.
// Configuration: cfg_we writes cfg_wdata into register cfg_index at once;
// indexes past the last register are ignored. Write only while idle.
// The pipeline has 37 register stages: matrix products, clip sums, divider
// setup, 31 restoring divider steps (one quotient bit per stage for x and y
// sharing the divisor), NDC finish, viewport multiply and output clamp.
// Throughput is one point per cycle while the receiver does not stall.
// Each stage holds its valid bit; a stage advances when it is empty or the
// stage after it advances, so bubbles fill while the receiver stalls and a
// held output does not block new points until the pipeline is full.
// Reset clears all valid bits and loads the default matrix (x row with world x
// weight 2^-16, identity y row, w = 1.0) and a 640 by 480 window.
`default_nettype none
module world_to_screen_transform_top (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire wst_pkg::wst_in_t        in_pt,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output wst_pkg::wst_out_t            out_pt,
	input  wire logic                    cfg_we,
	input  wire logic [wst_pkg::IDXW-1:0] cfg_index,
	input  wire logic [wst_pkg::CFGW-1:0] cfg_wdata
);

	localparam int QB      = wst_pkg::QB;
	localparam int CW      = wst_pkg::CW;
	localparam int F       = wst_pkg::F;
	localparam int SH      = QB - F;
	localparam int ST_DIV0 = 3;
	localparam int ST_S4   = QB + 3;
	localparam int ST_S5   = QB + 4;
	localparam int ST_S6   = QB + 5;
	localparam int NST     = QB + 6;

	logic [wst_pkg::CFGW-1:0] row_x_q;
	logic [wst_pkg::CFGW-1:0] row_y_q;
	logic [wst_pkg::CFGW-1:0] row_w_q;
	logic [wst_pkg::CFGW-1:0] off_xy_q;
	logic [CW-1:0]            off_w_q;
	logic [wst_pkg::SCRW-1:0] scr_w_q;
	logic [wst_pkg::SCRW-1:0] scr_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q  <= wst_pkg::RST_ROW_X;
			row_y_q  <= wst_pkg::RST_ROW_Y;
			row_w_q  <= wst_pkg::RST_ROW_W;
			off_xy_q <= wst_pkg::RST_OFF_XY;
			off_w_q  <= wst_pkg::RST_OFF_W;
			scr_w_q  <= wst_pkg::RST_SCR_W;
			scr_h_q  <= wst_pkg::RST_SCR_H;
		end else if (cfg_we) begin
			unique case (wst_pkg::wst_reg_t'(cfg_index))
				wst_pkg::REG_ROW_X:  row_x_q  <= cfg_wdata;
				wst_pkg::REG_ROW_Y:  row_y_q  <= cfg_wdata;
				wst_pkg::REG_ROW_W:  row_w_q  <= cfg_wdata;
				wst_pkg::REG_OFF_XY: off_xy_q <= cfg_wdata;
				wst_pkg::REG_OFF_W:  off_w_q  <= cfg_wdata[CW-1:0];
				wst_pkg::REG_SCR_W:  scr_w_q  <= cfg_wdata[wst_pkg::SCRW-1:0];
				wst_pkg::REG_SCR_H:  scr_h_q  <= cfg_wdata[wst_pkg::SCRW-1:0];
				default: ;
			endcase
		end
	end

	logic [NST-1:0] vld_s;
	logic [NST:0]   adv;

	assign adv[NST] = out_ready;
	for (genvar k = 0; k < NST; k++) begin : g_adv
		assign adv[k] = ~vld_s[k] | adv[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign in_ready = adv[0];

	logic signed [wst_pkg::PRODW-1:0] p_xa_s1, p_xb_s1, p_ya_s1, p_yb_s1, p_wa_s1, p_wb_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			p_xa_s1 <= $signed(row_x_q[63:32]) * in_pt.world_x;
			p_xb_s1 <= $signed(row_x_q[31:0]) * in_pt.world_y;
			p_ya_s1 <= $signed(row_y_q[63:32]) * in_pt.world_x;
			p_yb_s1 <= $signed(row_y_q[31:0]) * in_pt.world_y;
			p_wa_s1 <= $signed(row_w_q[63:32]) * in_pt.world_x;
			p_wb_s1 <= $signed(row_w_q[31:0]) * in_pt.world_y;
		end
	end

	logic signed [wst_pkg::PRODW-1:0] sum_x, sum_y, sum_w;
	logic signed [wst_pkg::CLIPW-1:0] clip_x_s2, clip_y_s2, clip_w_s2;

	always_comb begin
		sum_x = (p_xa_s1 >>> F) + (p_xb_s1 >>> F)
			+ wst_pkg::PRODW'($signed(off_xy_q[63:32]));
		sum_y = (p_ya_s1 >>> F) + (p_yb_s1 >>> F)
			+ wst_pkg::PRODW'($signed(off_xy_q[31:0]));
		sum_w = (p_wa_s1 >>> F) + (p_wb_s1 >>> F)
			+ wst_pkg::PRODW'($signed(off_w_q));
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			clip_x_s2 <= wst_pkg::CLIPW'(sum_x);
			clip_y_s2 <= wst_pkg::CLIPW'(sum_y);
			clip_w_s2 <= wst_pkg::CLIPW'(sum_w);
		end
	end

	logic [wst_pkg::MAGW-1:0] ua_x, ua_y, ub;
	wst_pkg::wst_div_t        dv_nxt;
	wst_pkg::wst_div_t        dv_s3;

	always_comb begin
		ua_x = clip_x_s2[wst_pkg::CLIPW-1] ? wst_pkg::MAGW'(-clip_x_s2)
			: wst_pkg::MAGW'(clip_x_s2);
		ua_y = clip_y_s2[wst_pkg::CLIPW-1] ? wst_pkg::MAGW'(-clip_y_s2)
			: wst_pkg::MAGW'(clip_y_s2);
		ub = clip_w_s2[wst_pkg::CLIPW-1] ? wst_pkg::MAGW'(-clip_w_s2)
			: wst_pkg::MAGW'(clip_w_s2);
		dv_nxt.ub    = ub;
		dv_nxt.rx    = ua_x >> SH;
		dv_nxt.ry    = ua_y >> SH;
		dv_nxt.lx    = {ua_x[SH-1:0], {F{1'b0}}};
		dv_nxt.ly    = {ua_y[SH-1:0], {F{1'b0}}};
		dv_nxt.qx    = '0;
		dv_nxt.qy    = '0;
		dv_nxt.neg_x = clip_x_s2[wst_pkg::CLIPW-1] ^ clip_w_s2[wst_pkg::CLIPW-1];
		dv_nxt.neg_y = clip_y_s2[wst_pkg::CLIPW-1] ^ clip_w_s2[wst_pkg::CLIPW-1];
		dv_nxt.ovf_x = {{SH{1'b0}}, ua_x} >= {ub, {SH{1'b0}}};
		dv_nxt.ovf_y = {{SH{1'b0}}, ua_y} >= {ub, {SH{1'b0}}};
		dv_nxt.zb    = (clip_w_s2 == '0);
		dv_nxt.zax   = (clip_x_s2 == '0);
		dv_nxt.zay   = (clip_y_s2 == '0);
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			dv_s3 <= dv_nxt;
		end
	end

	wst_pkg::wst_div_t dst [0:QB];

	assign dst[0] = dv_s3;

	for (genvar j = 0; j < QB; j++) begin : g_step
		wst_div_step u_step (
			.clk (clk),
			.en  (adv[ST_DIV0+j]),
			.d   (dst[j]),
			.q   (dst[j+1])
		);
	end

	localparam logic signed [CW-1:0] LIM  = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW:0]   ONE  = (CW+1)'(1) << F;

	wst_pkg::wst_div_t    dq;
	logic signed [CW-1:0] nx, ny;
	logic signed [CW:0]   sxp_s4, syp_s4;
	logic                 bad_s4;

	always_comb begin
		dq = dst[QB];
		if (dq.zb && dq.zax) begin
			nx = '0;
		end else if (dq.ovf_x) begin
			nx = dq.neg_x ? -LIM : LIM;
		end else begin
			nx = dq.neg_x ? -$signed({1'b0, dq.qx}) : $signed({1'b0, dq.qx});
		end
		if (dq.zb && dq.zay) begin
			ny = '0;
		end else if (dq.ovf_y) begin
			ny = dq.neg_y ? -LIM : LIM;
		end else begin
			ny = dq.neg_y ? -$signed({1'b0, dq.qy}) : $signed({1'b0, dq.qy});
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_S4]) begin
			sxp_s4 <= (CW+1)'(nx) + ONE;
			syp_s4 <= ONE - (CW+1)'(ny);
			bad_s4 <= dq.ovf_x | dq.ovf_y | dq.zb;
		end
	end

	logic signed [wst_pkg::MULW-1:0] sxm_s5, sym_s5;
	logic                            bad_s5;

	always_ff @(posedge clk) begin
		if (adv[ST_S5]) begin
			sxm_s5 <= sxp_s4 * $signed({1'b0, scr_w_q});
			sym_s5 <= syp_s4 * $signed({1'b0, scr_h_q});
			bad_s5 <= bad_s4;
		end
	end

	localparam logic signed [wst_pkg::MULW-1:0] CLAMP_HI = wst_pkg::MULW'(LIM);
	localparam logic signed [wst_pkg::MULW-1:0] CLAMP_LO = ~CLAMP_HI;

	logic signed [wst_pkg::MULW-1:0] shx, shy;
	logic                            hix, lox, hiy, loy;
	wst_pkg::wst_out_t               out_nxt;
	wst_pkg::wst_out_t               out_s6;

	always_comb begin
		shx = sxm_s5 >>> 1;
		shy = sym_s5 >>> 1;
		hix = shx > CLAMP_HI;
		lox = shx < CLAMP_LO;
		hiy = shy > CLAMP_HI;
		loy = shy < CLAMP_LO;
		out_nxt.pix_x     = hix ? LIM : (lox ? ~LIM : shx[CW-1:0]);
		out_nxt.pix_y     = hiy ? LIM : (loy ? ~LIM : shy[CW-1:0]);
		out_nxt.bad_point = bad_s5 | hix | lox | hiy | loy;
	end

	always_ff @(posedge clk) begin
		if (adv[ST_S6]) begin
			out_s6 <= out_nxt;
		end
	end

	assign out_valid = vld_s[NST-1];
	assign out_pt    = out_s6;

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s == '0) |-> in_ready)
		else $error("pipeline empty but input not ready");

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("receiver ready but input stalled");

	a_zero_w_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[ST_S4-1] && dq.zb) |-> (dq.ovf_x && dq.ovf_y))
		else $error("zero clip w not flagged as overflow");

endmodule
`default_nettype wire
